// ----- rtl/sha256_pkg.sv -----
package sha256_pkg;

    typedef logic [31:0] t_word;
    typedef t_word [0:15] t_block;
    typedef t_word [0:7]  t_hash;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // commands from the sequencer to the compression unit
    typedef struct packed {
        logic start;    // copy block and chaining value, begin 64 rounds
        logic iv_load;  // return chaining value to the initial hash
    } t_cmp_ctrl;

    typedef struct packed {
        logic busy;     // rounds in progress
        logic done;     // one-cycle pulse, chaining value updated at the edge that ends it
    } t_cmp_stat;

    localparam int ROUNDS     = 64;
    localparam int BLOCK_LAST = 63;
    localparam int LEN_START  = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam t_hash HASH_IV = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word big_s0(input t_word x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_s1(input t_word x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_s0(input t_word x);
        small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_s1(input t_word x);
        small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        unique case (idx)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

// ----- rtl/sha256_compress.sv -----
module sha256_compress (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_cmp_ctrl i_ctrl,
    input  sha256_pkg::t_block    i_block,
    output sha256_pkg::t_cmp_stat o_stat,
    output sha256_pkg::t_hash     o_hash
);
    import sha256_pkg::*;

    t_hash      r_hash, n_hash;
    t_hash      r_var, n_var;
    t_block     r_win, n_win;
    logic [5:0] r_rnd, n_rnd;
    logic       r_busy, n_busy;
    logic       r_fin, n_fin;

    t_word w_cur, w_next, t1, t2;

    // one round per cycle; window slot 0 is the word for the current round
    always_comb begin
        w_cur  = r_win[0];
        w_next = small_s1(r_win[14]) + r_win[9] + small_s0(r_win[1]) + r_win[0];
        t1 = r_var[7] + big_s1(r_var[4]) + ((r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]))
           + round_k(r_rnd) + w_cur;
        t2 = big_s0(r_var[0])
           + ((r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]));
    end

    always_comb begin
        n_hash = r_hash;
        n_var  = r_var;
        n_win  = r_win;
        n_rnd  = r_rnd;
        n_busy = r_busy;
        n_fin  = 1'b0;
        if (i_ctrl.iv_load) begin
            n_hash = HASH_IV;
        end
        if (i_ctrl.start) begin
            n_var  = r_hash;
            n_win  = i_block;
            n_rnd  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_var = '{t1 + t2, r_var[0], r_var[1], r_var[2],
                      r_var[3] + t1, r_var[4], r_var[5], r_var[6]};
            for (int i = 0; i < 15; i++) begin
                n_win[i] = r_win[i + 1];
            end
            n_win[15] = w_next;
            n_rnd = r_rnd + 6'd1;
            if (r_rnd == 6'(BLOCK_LAST)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
        if (r_fin) begin
            for (int i = 0; i < 8; i++) begin
                n_hash[i] = r_hash[i] + r_var[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= HASH_IV;
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_hash <= n_hash;
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_rnd  <= n_rnd;
        end
        r_var <= n_var;
        r_win <= n_win;
    end

    assign o_stat = '{busy: r_busy, done: r_fin};
    assign o_hash = r_hash;

endmodule

// ----- rtl/sha256_hash_engine_core.sv -----
// SHA-256 engine, one message byte per input transaction.
// Input channel: i_in_valid / o_in_ready carry i_in_data (data byte, last
// flag, empty-message flag). Output channel: o_out_valid / i_out_ready carry
// o_out_data, the eight digest words, word 0 first, last_word on word 7.
// After a byte that does not complete a 64-byte block, ready stays high for
// the next byte. A byte that completes a block adds a block copy, 64 rounds
// of the shared round unit and a chaining add. Ending a message adds a
// padding state, a length state and one or two more compressions, then the
// eight output transactions, at best one per cycle. The round unit sets the rate.
// Input is ready only while idle: not while padding, writing the length,
// compressing a block or sending the digest; under a stalled receiver the
// output holds word and index until taken.
// After word 7 the engine is back in its reset state: initial hash values,
// empty block, zero length. Reset (i_rst_n low, synchronous) does the same.
module sha256_hash_engine_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sha256_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sha256_pkg::t_out_item o_out_data
);
    import sha256_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // taking bytes
    localparam logic [2:0] S_GO   = 3'd1;  // hand block to round unit, clear it
    localparam logic [2:0] S_COMP = 3'd2;  // rounds running
    localparam logic [2:0] S_PAD  = 3'd3;  // write 0x80 marker
    localparam logic [2:0] S_LEN  = 3'd4;  // write 64-bit bit length
    localparam logic [2:0] S_OUT  = 3'd5;  // stream digest words

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_ret, n_ret;     // where to go once the compression is done
    t_block      r_blk, n_blk;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_bitlen, n_bitlen;
    logic [2:0]  r_idx, n_idx;

    t_cmp_ctrl   cmp_ctrl;
    t_cmp_stat   cmp_stat;
    t_hash       hash;
    logic        in_acc;
    logic        out_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_blk    = r_blk;
        n_pos    = r_pos;
        n_bitlen = r_bitlen;
        n_idx    = r_idx;
        cmp_ctrl = '{start: 1'b0, iv_load: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.empty_message) begin
                        // empty marker ends the message, no byte added
                        n_state = S_PAD;
                    end else begin
                        n_blk[r_pos[5:2]][(3 - r_pos[1:0]) * 8 +: 8] = i_in_data.data_byte;
                        n_bitlen = r_bitlen + 64'd8;
                        n_pos    = r_pos + 6'd1;
                        if (r_pos == 6'(BLOCK_LAST)) begin
                            // block full: compress; on a last byte, pad afterwards in a fresh block
                            n_state = S_GO;
                            n_ret   = i_in_data.last_byte ? S_PAD : S_IDLE;
                        end else if (i_in_data.last_byte) begin
                            n_state = S_PAD;
                        end
                    end
                end
            end
            S_PAD: begin
                n_blk[r_pos[5:2]][(3 - r_pos[1:0]) * 8 +: 8] = PAD_BYTE;
                if (r_pos >= 6'(LEN_START)) begin
                    // no room for the length: extra block
                    n_state = S_GO;
                    n_ret   = S_LEN;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_blk[14] = r_bitlen[63:32];
                n_blk[15] = r_bitlen[31:0];
                n_state   = S_GO;
                n_ret     = S_OUT;
            end
            S_GO: begin
                cmp_ctrl.start = 1'b1;
                n_blk   = '0;
                n_state = S_COMP;
            end
            S_COMP: begin
                if (cmp_stat.done) begin
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    if (r_idx == 3'd7) begin
                        cmp_ctrl.iv_load = 1'b1;
                        n_pos    = '0;
                        n_bitlen = '0;
                        n_idx    = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_blk    <= '0;
            r_pos    <= '0;
            r_bitlen <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_blk    <= n_blk;
            r_pos    <= n_pos;
            r_bitlen <= n_bitlen;
            r_idx    <= n_idx;
        end
    end

    sha256_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cmp_ctrl),
        .i_block (r_blk),
        .o_stat  (cmp_stat),
        .o_hash  (hash)
    );

    // chaining value is static while in S_OUT, so the word holds under stall
    assign o_out_data = '{digest_word: hash[r_idx],
                          word_index:  r_idx,
                          last_word:   (r_idx == 3'd7)};

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmp_ctrl.start |-> !cmp_stat.busy)
        else $error("compression started while rounds in progress");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmp_stat.done |=> !cmp_stat.done)
        else $error("done held longer than one cycle");

    a_sides_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while digest pending");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_data.last_word) |=>
            (r_pos == 6'd0 && r_bitlen == 64'd0 && o_in_ready && hash == HASH_IV))
        else $error("engine not back in reset state after digest");

endmodule

// ----- tb/sha256_digest_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the SHA-256 core, models the hash on every input
// transaction and compares each digest word against the oldest prediction.
module sha256_digest_checker
    import sha256_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int REPORT_MAX = 10;

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    t_word       chain_h [8];
    t_word       msg_w [16];
    logic [5:0]  fill_pos;
    logic [63:0] bit_count;
    t_out_item   digest_q [$];
    t_out_item   want_word;
    int          report_count;

    function automatic t_word ror32(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_hash_state();
        int i;
        for (i = 0; i < 8; i++) chain_h[i] = HASH_IV[i];
        for (i = 0; i < 16; i++) msg_w[i] = '0;
        fill_pos  = '0;
        bit_count = '0;
    endtask

    // 64 rounds over msg_w with a rolling 16-word schedule, add into chain_h, clear the block
    task automatic compress_msg_block();
        t_word w [16];
        t_word v [8];
        t_word wr, t1, t2, x2, x15;
        int    r, i;
        for (i = 0; i < 16; i++) w[i] = msg_w[i];
        for (i = 0; i < 8; i++) v[i] = chain_h[i];
        for (r = 0; r < 64; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                x2  = w[(r - 2) & 15];
                x15 = w[(r - 15) & 15];
                wr  = (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10)) + w[(r - 7) & 15]
                    + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + w[r & 15];
                w[r & 15] = wr;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + wr;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
        for (i = 0; i < 16; i++) msg_w[i] = '0;
    endtask

    task automatic place_byte(input logic [5:0] pos, input logic [7:0] b);
        int shift;
        shift = (3 - int'(pos[1:0])) * 8;
        msg_w[pos[5:2]] = msg_w[pos[5:2]] | (t_word'(b) << shift);
    endtask

    task automatic hash_input_item(input t_in_item it);
        logic      msg_end;
        t_out_item w_out;
        int        j;
        msg_end = 1'b1;
        // empty marker wins over a data byte, with or without the last flag
        if (!it.empty_message) begin
            place_byte(fill_pos, it.data_byte);
            bit_count = bit_count + 64'd8;
            fill_pos  = fill_pos + 6'd1;
            if (fill_pos == 6'd0) compress_msg_block();
            msg_end = it.last_byte;
        end
        if (msg_end) begin
            place_byte(fill_pos, PAD_BYTE);
            // no room for the length: one more block
            if (fill_pos >= LEN_START) compress_msg_block();
            msg_w[14] = bit_count[63:32];
            msg_w[15] = bit_count[31:0];
            compress_msg_block();
            for (j = 0; j < 8; j++) begin
                w_out.digest_word = chain_h[j];
                w_out.word_index  = j[2:0];
                w_out.last_word   = (j == 7);
                digest_q.push_back(w_out);
            end
            clear_hash_state();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_hash_state();
            digest_q.delete();
            report_count = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    if (report_count < REPORT_MAX)
                        $display("[%0t] digest word with nothing pending: word %h idx %0d last %b",
                                 $time, i_out_data.digest_word, i_out_data.word_index,
                                 i_out_data.last_word);
                    report_count++;
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want_word = digest_q.pop_front();
                    if (i_out_data.digest_word !== want_word.digest_word ||
                        i_out_data.word_index  !== want_word.word_index  ||
                        i_out_data.last_word   !== want_word.last_word) begin
                        if (report_count < REPORT_MAX)
                            $display("[%0t] digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     $time, want_word.digest_word, want_word.word_index,
                                     want_word.last_word, i_out_data.digest_word,
                                     i_out_data.word_index, i_out_data.last_word);
                        report_count++;
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) hash_input_item(i_in_data);
            o_pending <= digest_q.size();
        end
    end

endmodule

// ----- tb/tb_sha256_hash_engine_core.sv -----
`timescale 1ns / 100ps

module tb_sha256_hash_engine_core;
    import sha256_pkg::*;

    // watchdog limit; keep a wide margin
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 160;
    localparam int CALM_AFTER    = 130;   // random items before idling stops
    localparam int HOLD_TRIGGER  = 12;    // transactions sent before the long stall
    localparam int HOLD_CYCLES   = 1500;
    localparam int DRAIN_CYCLES  = 300;   // beyond the longest message-end latency

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int   fail_count;
    int   pending_count;
    int   sent_count = 0;
    int   cycle_count = 0;
    logic calm_tail = 1'b0;
    logic hold_done = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sha256_hash_engine_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    sha256_digest_checker u_digest_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_sha256_hash_engine_core: FAIL");
            $finish;
        end
    end

    function automatic t_in_item make_item(input logic [7:0] b, input logic last,
                                           input logic empty);
        t_in_item it;
        it.data_byte     = b;
        it.last_byte     = last;
        it.empty_message = empty;
        return it;
    endfunction

    // Offer one transaction at the falling edge, hold it until taken.
    // Called and returns at a falling edge.
    task automatic send_item(input t_in_item it);
        int gap;
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sent_count++;
        @(negedge clk);
    endtask

    // len random bytes; ends on last_byte, or on an empty marker carrying
    // random junk in its byte and last flag
    task automatic send_message(input int len, input logic by_marker);
        int i;
        for (i = 0; i < len; i++)
            send_item(make_item(8'($urandom), (i == len - 1) && !by_marker, 1'b0));
        if (by_marker || len == 0)
            send_item(make_item(8'($urandom), 1'($urandom), 1'b1));
    endtask

    // Output side: random low bursts, one long hold-off while the sender keeps
    // pushing so the core backs up into its input, and always ready in the tail.
    initial begin : out_ready_gen
        int   burst;
        logic level;
        burst = 0;
        level = 1'b1;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (calm_tail) begin
                out_ready <= 1'b1;
            end else if (!hold_done && sent_count >= HOLD_TRIGGER) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                if (burst == 0) begin
                    level = ($urandom_range(0, 2) != 0);
                    burst = level ? $urandom_range(1, 32) : $urandom_range(1, 16);
                end
                out_ready <= level;
                burst--;
            end
        end
    end

    initial begin : stimulus
        int rand_base;
        int len;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed ---
        send_item(make_item(8'h00, 1'b0, 1'b1));   // empty marker on a fresh message
        send_item(make_item(8'hff, 1'b1, 1'b1));   // both flags: marker wins
        send_item(make_item(8'h00, 1'b1, 1'b0));   // single zero byte
        send_item(make_item(8'hff, 1'b1, 1'b0));   // single all-ones byte
        send_item(make_item(8'h61, 1'b0, 1'b0));   // "abc"
        send_item(make_item(8'h62, 1'b0, 1'b0));
        send_item(make_item(8'h63, 1'b1, 1'b0));
        send_item(make_item(8'h55, 1'b0, 1'b0));   // pending bytes, then both flags
        send_item(make_item(8'haa, 1'b0, 1'b0));
        send_item(make_item(8'h12, 1'b1, 1'b1));
        send_item(make_item(8'hff, 1'b0, 1'b0));   // pending byte, then plain marker
        send_item(make_item(8'h00, 1'b0, 1'b1));

        // --- random ---
        rand_base = sent_count;
        send_message(56, 1'b0);   // pad lands in the length field: extra block
        send_message(64, 1'b0);   // last byte fills the block: padding in a fresh one
        while (sent_count - rand_base < RANDOM_ITEMS) begin
            if (sent_count - rand_base >= CALM_AFTER) calm_tail = 1'b1;
            len = $urandom_range(0, 12);
            send_message(len, (len == 0) || ($urandom_range(0, 3) == 0));
        end
        calm_tail = 1'b1;
        in_valid <= 1'b0;

        // drain, then give the core time to show any stray word
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_sha256_hash_engine_core: PASS");
        end else begin
            $display("tb_sha256_hash_engine_core: FAIL");
        end
        $finish;
    end

endmodule

// ----- sha256_hash_engine_core.f -----
rtl/sha256_pkg.sv
rtl/sha256_compress.sv
rtl/sha256_hash_engine_core.sv
tb/sha256_digest_checker.sv
tb/tb_sha256_hash_engine_core.sv
